@@ src/qrs_pkg.sv @@
// Shared types and constants for the QRS grouping R-peak locator.
// No dependencies; every other file refers to this package by scoped names.
package qrs_pkg;

  // Fixed widths of the result fields and configuration registers.
  localparam int unsigned PeakIndexWidth  = 16;
  localparam int unsigned PeakNumberWidth = 6;
  localparam int unsigned MinGapWidth     = 16;
  localparam int unsigned MaxPeaksWidth   = 7;
  localparam int unsigned CfgDataWidth    = 16;
  localparam int unsigned CfgAddrWidth    = 1;

  // Configuration register indexes.
  localparam logic [CfgAddrWidth-1:0] CFG_MIN_GAP   = 1'b0;
  localparam logic [CfgAddrWidth-1:0] CFG_MAX_PEAKS = 1'b1;

  // Register values after reset: 0.6 s at 360 Hz, and ten peaks per record.
  localparam logic [MinGapWidth-1:0]   MIN_GAP_RESET   = 16'd216;
  localparam logic [MaxPeaksWidth-1:0] MAX_PEAKS_RESET = 7'd10;

  // One result item.
  typedef struct packed {
    logic [PeakIndexWidth-1:0]  peak_index;
    logic [PeakNumberWidth-1:0] peak_number;
    logic                       final_peak;
  } result_t;

endpackage

@@ src/qrs_tracker.sv @@
// Complex tracker: record state and the per-sample grouping and peak search.
// Depends on qrs_pkg for the result type and register widths.
module qrs_tracker #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned INDEX_WIDTH  = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                fire_i,
  input  logic                                qrs_active_i,
  input  logic signed [SAMPLE_WIDTH-1:0]      sample_value_i,
  input  logic                                record_end_i,
  input  logic [qrs_pkg::MinGapWidth-1:0]     min_gap_i,
  input  logic [qrs_pkg::MaxPeaksWidth-1:0]   max_peaks_i,
  output logic                                res_valid_o,
  output qrs_pkg::result_t                    res_o
);

  localparam int unsigned GapCmpWidth =
    (INDEX_WIDTH > qrs_pkg::MinGapWidth) ? INDEX_WIDTH : qrs_pkg::MinGapWidth;

  logic [INDEX_WIDTH-1:0]             cnt_q, cnt_d;
  logic                               open_q, open_d;
  logic [INDEX_WIDTH-1:0]             first_q, first_d;
  logic [INDEX_WIDTH-1:0]             last_q, last_d;
  logic [SAMPLE_WIDTH-1:0]            comm_mag_q, comm_mag_d;
  logic [INDEX_WIDTH-1:0]             comm_pos_q, comm_pos_d;
  logic [SAMPLE_WIDTH-1:0]            pend_mag_q, pend_mag_d;
  logic [INDEX_WIDTH-1:0]             pend_pos_q, pend_pos_d;
  logic [qrs_pkg::MaxPeaksWidth-1:0]  given_q, given_d;
  logic                               halted_q, halted_d;

  logic [SAMPLE_WIDTH-1:0]            mag;
  logic [INDEX_WIDTH-1:0]             gap;
  logic                               gap_reached;
  logic                               emit;
  logic                               fin;
  logic [INDEX_WIDTH-1:0]             emit_pos;
  logic [GapCmpWidth-1:0]             gap_ext;
  logic [GapCmpWidth-1:0]             min_gap_ext;

  // Two's complement negate; the most negative value maps onto 2^(W-1) unsigned.
  assign mag = sample_value_i[SAMPLE_WIDTH-1] ? (~sample_value_i + 1'b1) : sample_value_i;

  assign gap         = cnt_q - last_q;
  assign gap_ext     = GapCmpWidth'(gap);
  assign min_gap_ext = GapCmpWidth'(min_gap_i);
  assign gap_reached = (gap_ext >= min_gap_ext);

  always_comb begin
    cnt_d      = cnt_q + 1'b1;
    open_d     = open_q;
    first_d    = first_q;
    last_d     = last_q;
    comm_mag_d = comm_mag_q;
    comm_pos_d = comm_pos_q;
    pend_mag_d = pend_mag_q;
    pend_pos_d = pend_pos_q;
    given_d    = given_q;
    halted_d   = halted_q;
    emit       = 1'b0;
    fin        = 1'b0;
    emit_pos   = comm_pos_q;

    if (!halted_q) begin
      if (!open_q) begin
        if (qrs_active_i) begin
          open_d     = 1'b1;
          first_d    = cnt_q;
          last_d     = cnt_q;
          comm_mag_d = '0;
          comm_pos_d = cnt_q;
          pend_mag_d = mag;
          pend_pos_d = cnt_q;
        end
      end else if (qrs_active_i) begin
        if (gap_reached) begin
          if (given_q < max_peaks_i) begin
            // The committed best of the closing complex goes out, a new one opens here.
            emit       = 1'b1;
            emit_pos   = comm_pos_q;
            first_d    = cnt_q;
            last_d     = cnt_q;
            comm_mag_d = '0;
            comm_pos_d = cnt_q;
            pend_mag_d = mag;
            pend_pos_d = cnt_q;
          end else begin
            halted_d = 1'b1;
          end
        end else begin
          // Same complex: fold the pending run into the committed best.
          if (pend_mag_q > comm_mag_q) begin
            comm_mag_d = pend_mag_q;
            comm_pos_d = pend_pos_q;
          end
          last_d     = cnt_q;
          pend_mag_d = mag;
          pend_pos_d = cnt_q;
        end
      end else if (mag > pend_mag_q) begin
        pend_mag_d = mag;
        pend_pos_d = cnt_q;
      end
    end

    if (record_end_i) begin
      if (!emit && !halted_d && open_d && (last_d != first_d) && (given_q < max_peaks_i)) begin
        emit     = 1'b1;
        fin      = 1'b1;
        emit_pos = comm_pos_d;
      end
      cnt_d      = '0;
      open_d     = 1'b0;
      first_d    = '0;
      last_d     = '0;
      comm_mag_d = '0;
      comm_pos_d = '0;
      pend_mag_d = '0;
      pend_pos_d = '0;
      given_d    = '0;
      halted_d   = 1'b0;
    end else if (emit) begin
      given_d = given_q + 1'b1;
    end
  end

  always_comb begin
    res_valid_o       = emit;
    res_o.peak_index  = qrs_pkg::PeakIndexWidth'(emit_pos);
    res_o.peak_number = given_q[qrs_pkg::PeakNumberWidth-1:0];
    res_o.final_peak  = fin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      open_q     <= 1'b0;
      first_q    <= '0;
      last_q     <= '0;
      comm_mag_q <= '0;
      comm_pos_q <= '0;
      pend_mag_q <= '0;
      pend_pos_q <= '0;
      given_q    <= '0;
      halted_q   <= 1'b0;
    end else if (fire_i) begin
      cnt_q      <= cnt_d;
      open_q     <= open_d;
      first_q    <= first_d;
      last_q     <= last_d;
      comm_mag_q <= comm_mag_d;
      comm_pos_q <= comm_pos_d;
      pend_mag_q <= pend_mag_d;
      pend_pos_q <= pend_pos_d;
      given_q    <= given_d;
      halted_q   <= halted_d;
    end
  end

endmodule

@@ src/qrs_out_reg.sv @@
// Result register with valid/ready handshake towards the receiver.
// Depends on qrs_pkg for the result type.
module qrs_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  qrs_pkg::result_t data_i,
  input  logic             ready_i,
  output logic             free_o,
  output logic             valid_o,
  output qrs_pkg::result_t data_o
);

  logic             vld_q, vld_d;
  qrs_pkg::result_t data_q;

  // The register can take a new result when empty or when its item leaves now.
  assign free_o = !vld_q || ready_i;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = vld_q;
  assign data_o  = data_q;

endmodule

@@ src/qrs_grouping_r_peak_locator_top.sv @@
// Top level of the QRS grouping R-peak locator: input register, configuration
// registers, tracker and result register. Depends on qrs_pkg, qrs_tracker, qrs_out_reg.
//
// Usage. Each input item is one ECG sample with its QRS-activity flag and a
// flag marking the last sample of a record. Items enter on the in_valid_i /
// in_ready_o channel; peak indices leave on the out_valid_o / out_ready_i
// channel, at most one result item per input item, in sample order.
// An accepted item is held in the input register until the result register has
// room; the tracker then processes it, updates the record state and, when a
// complex closes or a record ends with an open complex of more than one active
// sample, loads the result register, so a result passes both registers. The
// block sustains one item per cycle while the receiver keeps up, the rate set
// by the single register-to-register tracker update.
// When the receiver stalls, the result register holds its item and the
// input register keeps one further item; in_ready_o then drops until the
// result register drains, so nothing is lost or repeated.
// Configuration: min_gap (index 0) and max_peaks (index 1) are to be written through
// cfg_we_i / cfg_addr_i / cfg_wdata_i only while the block is idle (not enforced).
// Reset (asynchronous, active low) empties both registers, clears the record
// state and restores min_gap to 216 and max_peaks to 10.
module qrs_grouping_r_peak_locator_top #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned INDEX_WIDTH  = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration write port.
  input  logic                                 cfg_we_i,
  input  logic [qrs_pkg::CfgAddrWidth-1:0]     cfg_addr_i,
  input  logic [qrs_pkg::CfgDataWidth-1:0]     cfg_wdata_i,
  // Sample channel.
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 qrs_active_i,
  input  logic signed [SAMPLE_WIDTH-1:0]       sample_value_i,
  input  logic                                 record_end_i,
  // Peak channel.
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [qrs_pkg::PeakIndexWidth-1:0]   peak_index_o,
  output logic [qrs_pkg::PeakNumberWidth-1:0]  peak_number_o,
  output logic                                 final_peak_o
);

  // Configuration registers.
  logic [qrs_pkg::MinGapWidth-1:0]   min_gap_q;
  logic [qrs_pkg::MaxPeaksWidth-1:0] max_peaks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_gap_q   <= qrs_pkg::MIN_GAP_RESET;
      max_peaks_q <= qrs_pkg::MAX_PEAKS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        qrs_pkg::CFG_MIN_GAP: begin
          min_gap_q <= cfg_wdata_i[qrs_pkg::MinGapWidth-1:0];
        end
        qrs_pkg::CFG_MAX_PEAKS: begin
          max_peaks_q <= cfg_wdata_i[qrs_pkg::MaxPeaksWidth-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Input register. It holds one item until the tracker processes it, which
  // happens as soon as the result register has room for a possible result.
  logic                           in_vld_q;
  logic                           active_q;
  logic signed [SAMPLE_WIDTH-1:0] sample_q;
  logic                           end_q;
  logic                           out_free;
  logic                           fire;
  logic                           in_take;

  assign fire       = in_vld_q && out_free;
  assign in_ready_o = !in_vld_q || fire;
  assign in_take    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      active_q <= qrs_active_i;
      sample_q <= sample_value_i;
      end_q    <= record_end_i;
    end
  end

  // Tracker: record state and the decision for the held item.
  logic             res_valid;
  qrs_pkg::result_t res;

  qrs_tracker #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .INDEX_WIDTH (INDEX_WIDTH)
  ) u_tracker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .qrs_active_i  (active_q),
    .sample_value_i(sample_q),
    .record_end_i  (end_q),
    .min_gap_i     (min_gap_q),
    .max_peaks_i   (max_peaks_q),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  // Result register facing the receiver.
  qrs_pkg::result_t out_data;

  qrs_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (fire && res_valid),
    .data_i (res),
    .ready_i(out_ready_i),
    .free_o (out_free),
    .valid_o(out_valid_o),
    .data_o (out_data)
  );

  assign peak_index_o  = out_data.peak_index;
  assign peak_number_o = out_data.peak_number;
  assign final_peak_o  = out_data.final_peak;

endmodule

@@ src/qrs_checker.sv @@
// Port-level checker for the QRS grouping R-peak locator, bound to the top level.
// Depends on qrs_pkg for field widths.
module qrs_checker #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_ready_o,
  input logic                                 qrs_active_i,
  input logic signed [SAMPLE_WIDTH-1:0]       sample_value_i,
  input logic                                 record_end_i,
  input logic                                 out_valid_o,
  input logic                                 out_ready_i,
  input logic [qrs_pkg::PeakIndexWidth-1:0]   peak_index_o,
  input logic [qrs_pkg::PeakNumberWidth-1:0]  peak_number_o,
  input logic                                 final_peak_o
);

  // A sample item that waits for acceptance stays offered, unchanged.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_ready_o) |=>
      (in_valid_i && $stable(qrs_active_i) && $stable(sample_value_i)
       && $stable(record_end_i)))
    else $error("sample item changed or vanished while waiting");

  // A result item that is not taken stays, unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(peak_index_o) && $stable(peak_number_o)
       && $stable(final_peak_o)))
    else $error("result item changed or vanished while stalled");

  // The sample side only stalls while a result waits for a stalled receiver.
  a_in_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without a waiting result");

  // A fresh result comes from an accepted item that passed the input register first.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result appeared without an accepted item");

endmodule

bind qrs_grouping_r_peak_locator_top qrs_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_qrs_checker (.*);

@@ tb/sv/qrs_grouping_r_peak_locator_top_tb.sv @@
// Self-checking testbench for the QRS grouping R-peak locator top level.
// Depends on qrs_pkg and qrs_grouping_r_peak_locator_top; predicts every peak item in-line.
module qrs_grouping_r_peak_locator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // One ECG sample as the record builder queues it before sending.
  typedef struct packed {
    logic        active;
    logic [15:0] value;
  } ecg_sample_t;

  // Minimum number of sample items the whole run sends, directed tests included.
  localparam int unsigned ItemTarget = 650;

  logic                                clk_i          = 1'b0;
  logic                                rst_ni         = 1'b0;
  logic                                cfg_we_i       = 1'b0;
  logic [qrs_pkg::CfgAddrWidth-1:0]    cfg_addr_i     = qrs_pkg::CFG_MIN_GAP;
  logic [qrs_pkg::CfgDataWidth-1:0]    cfg_wdata_i    = '0;
  logic                                in_valid_i     = 1'b0;
  logic                                in_ready_o;
  logic                                qrs_active_i   = 1'b0;
  logic signed [15:0]                  sample_value_i = '0;
  logic                                record_end_i   = 1'b0;
  logic                                out_valid_o;
  logic                                out_ready_i    = 1'b0;
  logic [qrs_pkg::PeakIndexWidth-1:0]  peak_index_o;
  logic [qrs_pkg::PeakNumberWidth-1:0] peak_number_o;
  logic                                final_peak_o;

  qrs_grouping_r_peak_locator_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .qrs_active_i   (qrs_active_i),
    .sample_value_i (sample_value_i),
    .record_end_i   (record_end_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .peak_index_o   (peak_index_o),
    .peak_number_o  (peak_number_o),
    .final_peak_o   (final_peak_o)
  );

  always #5 clk_i = ~clk_i;

  // Peak items that the tracker model has produced and the block has not yet delivered.
  qrs_pkg::result_t expected_peaks[$];
  int unsigned      mismatches   = 0;
  int unsigned      samples_sent = 0;

  // Idling controls. Each test may switch idling off to get stretches of full-rate traffic,
  // and the back-pressure test asks the receiver for one long hold-off through
  // ready_hold_cycles, which the receiver process counts down itself.
  bit          sender_idling     = 1'b1;
  bit          receiver_idling   = 1'b1;
  int unsigned ready_hold_cycles = 0;

  // Tracker model: our own copy of the configuration registers and of the record state.
  logic [15:0] min_gap_q   = qrs_pkg::MIN_GAP_RESET;
  logic [6:0]  max_peaks_q = qrs_pkg::MAX_PEAKS_RESET;
  logic [15:0] rec_index   = '0;
  logic        cx_open     = 1'b0;
  logic [15:0] cx_first    = '0;
  logic [15:0] cx_last     = '0;
  logic [15:0] best_mag    = '0;
  logic [15:0] best_pos    = '0;
  logic [15:0] tail_mag    = '0;
  logic [15:0] tail_pos    = '0;
  logic [6:0]  peaks_out   = '0;
  logic        search_halted = 1'b0;

  // The magnitude is unsigned, so the most negative sample maps exactly onto 2^15.
  function automatic logic [15:0] magnitude(input logic [15:0] raw);
    return raw[15] ? (~raw + 16'd1) : raw;
  endfunction

  function automatic void start_complex(input logic [15:0] idx, input logic [15:0] mag);
    cx_open  = 1'b1;
    cx_first = idx;
    cx_last  = idx;
    best_mag = '0;
    best_pos = idx;
    tail_mag = mag;
    tail_pos = idx;
  endfunction

  function automatic void queue_peak(input logic [15:0] pos, input logic flush);
    qrs_pkg::result_t peak;
    peak.peak_index  = pos;
    peak.peak_number = peaks_out[5:0];
    peak.final_peak  = flush;
    expected_peaks.push_back(peak);
    peaks_out = peaks_out + 7'd1;
  endfunction

  // Advances the record state by one accepted sample. The best magnitude is split in two:
  // the part of the complex before its last active sample (best_*), which is what a
  // closing complex reports, and the tail from that sample onwards (tail_*), which only
  // joins the best once a further active sample arrives within the gap.
  function automatic void track_sample(input logic active, input logic [15:0] value,
                                       input logic last);
    logic [15:0] idx;
    logic [15:0] mag;
    logic [15:0] distance;
    logic        produced;
    idx      = rec_index;
    mag      = magnitude(value);
    distance = idx - cx_last;
    produced = 1'b0;
    if (!search_halted) begin
      if (!cx_open) begin
        if (active) start_complex(idx, mag);
      end else if (active) begin
        if (distance >= min_gap_q) begin
          if (peaks_out < max_peaks_q) begin
            queue_peak(best_pos, 1'b0);
            produced = 1'b1;
            start_complex(idx, mag);
          end else begin
            search_halted = 1'b1;
          end
        end else begin
          if (tail_mag > best_mag) begin
            best_mag = tail_mag;
            best_pos = tail_pos;
          end
          cx_last  = idx;
          tail_mag = mag;
          tail_pos = idx;
        end
      end else if (mag > tail_mag) begin
        tail_mag = mag;
        tail_pos = idx;
      end
    end
    rec_index = rec_index + 16'd1;
    if (last) begin
      // The end-of-record flush only reports a complex that spans more than one active sample.
      if (!produced && !search_halted && cx_open && cx_last != cx_first &&
          peaks_out < max_peaks_q) begin
        queue_peak(best_pos, 1'b1);
      end
      rec_index     = '0;
      cx_open       = 1'b0;
      cx_first      = '0;
      cx_last       = '0;
      best_mag      = '0;
      best_pos      = '0;
      tail_mag      = '0;
      tail_pos      = '0;
      peaks_out     = '0;
      search_halted = 1'b0;
    end
  endfunction

  // Mostly short gaps, now and then a long one; never zero, so every gap really idles.
  function automatic int unsigned idle_length();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(12, 48) : $urandom_range(1, 3);
  endfunction

  // Sample values lean towards the extremes so that ties and the most negative value occur.
  function automatic logic [15:0] random_value();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'h8001;
      default: return 16'($urandom);
    endcase
  endfunction

  // Sends one sample item and updates the model at the edge where it is accepted.
  // Valid stays high between back-to-back items; it only drops for a gap or a drain.
  task automatic send_sample(input logic active, input logic [15:0] value, input logic last);
    int unsigned pause;
    pause = (sender_idling && $urandom_range(0, 2) == 0) ? idle_length() : 0;
    if (pause != 0) begin
      in_valid_i <= 1'b0;
      repeat (pause) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    qrs_active_i   <= active;
    sample_value_i <= value;
    record_end_i   <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    track_sample(active, value, last);
    samples_sent++;
  endtask

  // Stops offering items until every predicted peak has been delivered, then lets the
  // last items that cause no peak pass through the two register stages.
  task automatic drain_peaks();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_peaks.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Both registers are rewritten on every change of setting, always with the block idle.
  task automatic configure(input logic [15:0] gap, input logic [15:0] peaks);
    drain_peaks();
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= qrs_pkg::CFG_MIN_GAP;
    cfg_wdata_i <= gap;
    @(posedge clk_i);
    min_gap_q    = gap;
    cfg_addr_i  <= qrs_pkg::CFG_MAX_PEAKS;
    cfg_wdata_i <= peaks;
    @(posedge clk_i);
    max_peaks_q  = peaks[6:0];
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  // With the reset settings, a complex whose samples are all zero reports its start index
  // at the end-of-record flush.
  task automatic test_default_settings();
    send_sample(1'b1, 16'h0000, 1'b0);
    send_sample(1'b0, 16'h0000, 1'b0);
    send_sample(1'b1, 16'h0000, 1'b1);
  endtask

  // Complex opening, the search window stopping short of the last active sample, the first
  // of equal magnitudes winning, and a boundary exactly at the minimum gap.
  task automatic test_complex_boundaries();
    configure(16'd3, 16'd64);
    send_sample(1'b0, 16'h0064, 1'b0);
    send_sample(1'b1, 16'h8000, 1'b0);
    send_sample(1'b0, 16'h7FFF, 1'b0);
    send_sample(1'b1, 16'h0005, 1'b0);
    send_sample(1'b0, 16'h8000, 1'b0);
    send_sample(1'b0, 16'h0000, 1'b0);
    send_sample(1'b1, 16'h0001, 1'b0);
    send_sample(1'b1, 16'hFFFF, 1'b0);
    send_sample(1'b1, 16'h0001, 1'b0);
    send_sample(1'b0, 16'h0000, 1'b1);
  endtask

  // A zero gap makes every later active sample a boundary; the limit then halts the search
  // and suppresses the flush. A limit of zero halts at the very first boundary.
  task automatic test_peak_limit();
    configure(16'd0, 16'd1);
    send_sample(1'b1, 16'h1234, 1'b0);
    send_sample(1'b1, 16'hEDCC, 1'b0);
    send_sample(1'b1, 16'h7FFF, 1'b0);
    send_sample(1'b0, 16'h8000, 1'b0);
    send_sample(1'b1, 16'h0002, 1'b1);
    configure(16'd0, 16'd0);
    send_sample(1'b1, 16'h4000, 1'b0);
    send_sample(1'b1, 16'hC000, 1'b0);
    send_sample(1'b1, 16'h0001, 1'b1);
  endtask

  // A record of one active sample has no second active sample and so nothing to flush,
  // whereas a longer one flushes even with the widest gap and a limit above 64.
  task automatic test_single_sample_flush();
    configure(16'hFFFF, 16'd127);
    send_sample(1'b1, 16'h8000, 1'b1);
    send_sample(1'b0, 16'h7FFF, 1'b0);
    send_sample(1'b1, 16'h0010, 1'b0);
    send_sample(1'b0, 16'hFFF0, 1'b0);
    send_sample(1'b1, 16'h0001, 1'b1);
  endtask

  // Each later sample closes a complex, so peaks come at full rate while the receiver holds off.
  // The block must fill up and stall its input. The count passes 64, so the ordinal wraps.
  task automatic test_back_pressure();
    int unsigned n;
    configure(16'd1, 16'd127);
    sender_idling     = 1'b0;
    receiver_idling   = 1'b0;
    ready_hold_cycles = 150;
    for (n = 0; n < 90; n++) send_sample(1'b1, random_value(), n == 89);
    drain_peaks();
    sender_idling   = 1'b1;
    receiver_idling = 1'b1;
  endtask

  function automatic ecg_sample_t filler(input bit noisy);
    ecg_sample_t s;
    s.active = noisy && $urandom_range(0, 3) == 0;
    s.value  = random_value();
    return s;
  endfunction

  // Builds a record of heartbeats: bursts of active samples, with quiet stretches around the
  // current gap, up to 12, so both sides of the threshold are hit. Some beats carry stray activity.
  task automatic send_random_record();
    ecg_sample_t rec[$];
    ecg_sample_t s;
    int unsigned reach;
    int unsigned beats;
    int unsigned burst;
    int unsigned run;
    int unsigned b;
    int unsigned k;
    bit          noisy;
    reach = (min_gap_q == 0) ? 1 : ((min_gap_q > 12) ? 12 : min_gap_q);
    if ($urandom_range(0, 9) == 0) begin
      s.active = 1'($urandom);
      s.value  = random_value();
      rec.push_back(s);
    end else begin
      repeat ($urandom_range(0, 3)) rec.push_back(filler(1'b0));
      beats = $urandom_range(1, 6);
      for (b = 0; b < beats; b++) begin
        noisy = ($urandom_range(0, 5) == 0);
        burst = $urandom_range(1, 4);
        for (k = 0; k < burst; k++) begin
          s.active = 1'b1;
          s.value  = random_value();
          rec.push_back(s);
          if (k + 1 < burst) repeat ($urandom_range(0, reach - 1)) rec.push_back(filler(noisy));
        end
        run = $urandom_range((reach >= 2) ? reach - 2 : 0, reach + 3);
        repeat (run) rec.push_back(filler(noisy));
      end
      // Half of the records end on an active sample rather than on quiet ones.
      if ($urandom_range(0, 1) == 1) begin
        while (rec.size() > 1 && !rec[$].active) void'(rec.pop_back());
      end
    end
    foreach (rec[i]) begin
      if ($urandom_range(0, 59) == 0) drain_peaks();
      send_sample(rec[i].active, rec[i].value, i == rec.size() - 1);
    end
  endtask

  // Phases of random records, each under its own setting and its own mix of idling, until
  // the run as a whole has sent its share of items.
  task automatic test_random_records();
    while (samples_sent < ItemTarget) begin
      case ($urandom_range(0, 5))
        0:       configure(16'd1, 16'd64);
        1:       configure(qrs_pkg::MIN_GAP_RESET, 16'(qrs_pkg::MAX_PEAKS_RESET));
        2:       configure(16'hFFFF, 16'd1);
        3:       configure(16'($urandom_range(2, 12)), 16'($urandom_range(1, 8)));
        4:       configure(16'($urandom_range(2, 12)), 16'd64);
        default: configure(16'($urandom_range(1, 4)), 16'($urandom_range(1, 3)));
      endcase
      sender_idling   = ($urandom_range(0, 3) != 0);
      receiver_idling = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(3, 8)) begin
        if (samples_sent < ItemTarget) send_random_record();
      end
    end
  endtask

  // Receiver. A requested hold-off takes priority; otherwise random stalls while idling is on.
  // Ready is raised again in a later step than the one that lowered it.
  initial begin
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (ready_hold_cycles != 0) begin
        out_ready_i <= 1'b0;
        repeat (ready_hold_cycles) @(posedge clk_i);
        ready_hold_cycles = 0;
      end else if (receiver_idling && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat (idle_length()) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  // Checker. Every delivered peak is matched against the oldest prediction.
  qrs_pkg::result_t got_peak;
  qrs_pkg::result_t want_peak;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_peak = '{peak_index_o, peak_number_o, final_peak_o};
      if (expected_peaks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected peak item: index %0d number %0d final %0d",
                   got_peak.peak_index, got_peak.peak_number, got_peak.final_peak);
        end
      end else begin
        want_peak = expected_peaks.pop_front();
        if (got_peak.peak_index != want_peak.peak_index ||
            got_peak.peak_number != want_peak.peak_number ||
            got_peak.final_peak != want_peak.final_peak) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("peak mismatch: expected index %0d number %0d final %0d",
                     want_peak.peak_index, want_peak.peak_number, want_peak.final_peak);
            $display("               got      index %0d number %0d final %0d",
                     got_peak.peak_index, got_peak.peak_number, got_peak.final_peak);
          end
        end
      end
    end
  end

  // Main sequence: reset once, then each test in turn, then the verdict once the block is quiet.
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_settings();
    test_complex_boundaries();
    test_peak_limit();
    test_single_sample_flush();
    test_back_pressure();
    test_random_records();
    drain_peaks();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && expected_peaks.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: several times the length of the slowest correct run.
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
